/* hdl/smq_pkg.sv */
// smq_pkg: shared types, constants and helper functions for the scrolling marquee
// used by smq_cell and scrolling_marquee_text; no dependencies
package smq_pkg;

  localparam int unsigned DisplayWidth = 20;
  localparam int unsigned MaxInserts   = 16;

  localparam int unsigned TagW   = $clog2(DisplayWidth);
  localparam int unsigned IpW    = $clog2(DisplayWidth + 1);
  localparam int unsigned CountW = $clog2(MaxInserts + 1);

  localparam logic [7:0] KeyReverse = 8'h3C;
  localparam logic [7:0] KeyExit    = 8'h23;
  localparam logic [7:0] KeyDigLo   = 8'd48;
  localparam logic [7:0] KeyDigHi   = 8'd57;
  localparam logic [7:0] KeyUpLo    = 8'd65;
  localparam logic [7:0] KeyUpHi    = 8'd90;
  localparam logic [7:0] KeyLoLo    = 8'd97;
  localparam logic [7:0] KeyLoHi    = 8'd122;

  localparam logic [7:0] GlyphRight = 8'h3E;
  localparam logic [7:0] GlyphLeft  = 8'h3C;
  localparam logic [7:0] GlyphSpace = 8'h20;

  typedef logic [TagW-1:0]   tag_t;
  typedef logic [IpW-1:0]    ip_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    OpHold,
    OpInsert,
    OpLeft,
    OpRight
  } smq_op_e;

  typedef struct packed {
    smq_op_e    op;
    logic [7:0] key;
    ip_t        ip;
  } smq_ctrl_t;

  function automatic logic [7:0] reset_glyph(int unsigned k);
    logic [7:0] g;
    if (k < 2) begin
      g = GlyphRight;
    end else if (k < 4) begin
      g = GlyphLeft;
    end else begin
      g = GlyphSpace;
    end
    return g;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return ((c >= KeyDigLo) && (c <= KeyDigHi)) ||
           ((c >= KeyUpLo) && (c <= KeyUpHi)) ||
           ((c >= KeyLoLo) && (c <= KeyLoHi));
  endfunction

endpackage

/* hdl/smq_cell.sv */
// smq_cell: one display cell of the marquee ring, holding a glyph and its text position
// depends on smq_pkg
module smq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smq_pkg::smq_ctrl_t ctrl_i,
  input  logic [7:0]        rst_glyph_i,
  input  smq_pkg::tag_t     rst_tag_i,
  input  logic [7:0]        left_glyph_i,
  input  smq_pkg::tag_t     left_tag_i,
  input  logic [7:0]        right_glyph_i,
  input  smq_pkg::tag_t     right_tag_i,
  output logic [7:0]        glyph_o,
  output smq_pkg::tag_t     tag_o
);
  import smq_pkg::*;

  logic [7:0] glyph_q, glyph_d;
  tag_t       tag_q, tag_d;
  ip_t        pos;

  assign pos = ip_t'(tag_q);

  always_comb begin
    glyph_d = glyph_q;
    tag_d   = tag_q;
    unique case (ctrl_i.op)
      OpInsert: begin
        if (pos == ctrl_i.ip) begin
          glyph_d = ctrl_i.key;
        end else if (pos > ctrl_i.ip) begin
          glyph_d = left_glyph_i;
        end
      end
      OpLeft: begin
        glyph_d = right_glyph_i;
        tag_d   = right_tag_i;
      end
      OpRight: begin
        glyph_d = left_glyph_i;
        tag_d   = left_tag_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_q <= rst_glyph_i;
      tag_q   <= rst_tag_i;
    end else begin
      glyph_q <= glyph_d;
      tag_q   <= tag_d;
    end
  end

  assign glyph_o = glyph_q;
  assign tag_o   = tag_q;

endmodule

/* hdl/scrolling_marquee_text.sv */
// scrolling_marquee_text: top level, tick sequencer around a ring of smq_cell
// depends on smq_pkg and smq_cell
//
//   chan  handshake                  dir     transaction
//   in    in_valid_i / in_ready_o    sink    one frame tick: has_key_i, key_code_i
//   out   out_valid_o / out_ready_i  source  one column: glyph_o, column_last_o, exit_seen_o
//
// a tick passes the idle state that accepts it and the align state, then yields one column
// per cycle without stalls as the ring rotates left under cell 0
// the key insert is applied to all cells at the edge that accepts the tick
// reset loads the start text; after an exit tick later ticks are taken and dropped
// out stalls freeze the ring; in_ready_o is low while a frame is pending
module scrolling_marquee_text (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       has_key_i,
  input  logic [7:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] glyph_o,
  output logic       column_last_o,
  output logic       exit_seen_o
);
  import smq_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StAlign = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  localparam tag_t LastCol = tag_t'(DisplayWidth - 1);

  logic [1:0] state_q, state_d;
  tag_t       col_q, col_d;
  logic       backward_q, backward_d;
  logic       exit_q, exit_d;
  logic       halted_q, halted_d;
  ip_t        ip_q, ip_d;
  count_t     count_q, count_d;
  smq_ctrl_t  ctrl;

  logic [7:0] glyph [DisplayWidth];
  tag_t       tag   [DisplayWidth];

  logic in_fire, out_fire, key_rev, key_exit, do_insert;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign in_fire     = in_valid_i && in_ready_o && !halted_q;
  assign out_fire    = out_valid_o && out_ready_i;

  assign key_rev   = has_key_i && (key_code_i == KeyReverse);
  assign key_exit  = has_key_i && (key_code_i == KeyExit);
  assign do_insert = has_key_i && is_alnum(key_code_i) &&
                     (count_q < count_t'(MaxInserts)) && (ip_q < ip_t'(DisplayWidth));

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    backward_d = backward_q;
    exit_d     = exit_q;
    halted_d   = halted_q;
    ip_d       = ip_q;
    count_d    = count_q;
    ctrl.op    = OpHold;
    ctrl.key   = key_code_i;
    ctrl.ip    = ip_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          backward_d = backward_q ^ key_rev;
          exit_d     = key_exit;
          state_d    = StAlign;
          if (do_insert) begin
            ctrl.op = OpInsert;
            ip_d    = ip_q + ip_t'(1);
            count_d = count_q + count_t'(1);
          end
        end
      end
      StAlign: begin
        ctrl.op = backward_q ? OpRight : OpLeft;
        col_d   = '0;
        state_d = StEmit;
      end
      StEmit: begin
        if (out_fire) begin
          ctrl.op = OpLeft;
          col_d   = col_q + tag_t'(1);
          if (col_q == LastCol) begin
            state_d  = StIdle;
            halted_d = exit_q;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      col_q      <= '0;
      backward_q <= 1'b0;
      exit_q     <= 1'b0;
      halted_q   <= 1'b0;
      ip_q       <= ip_t'(2);
      count_q    <= '0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      backward_q <= backward_d;
      exit_q     <= exit_d;
      halted_q   <= halted_d;
      ip_q       <= ip_d;
      count_q    <= count_d;
    end
  end

  for (genvar k = 0; k < DisplayWidth; k++) begin : g_cell
    localparam int unsigned Left  = (k + DisplayWidth - 1) % DisplayWidth;
    localparam int unsigned Right = (k + 1) % DisplayWidth;
    smq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .rst_glyph_i   (reset_glyph(k)),
      .rst_tag_i     (tag_t'(k)),
      .left_glyph_i  (glyph[Left]),
      .left_tag_i    (tag[Left]),
      .right_glyph_i (glyph[Right]),
      .right_tag_i   (tag[Right]),
      .glyph_o       (glyph[k]),
      .tag_o         (tag[k])
    );
  end

  assign glyph_o       = glyph[0];
  assign column_last_o = (col_q == LastCol);
  assign exit_seen_o   = exit_q;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a frame is pending");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && column_last_o) |=> in_ready_o)
    else $error("sequencer did not return to idle after last column");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt cleared without reset");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(MaxInserts))
    else $error("insert count over limit");

  a_exit_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && column_last_o && exit_seen_o) |=> halted_q)
    else $error("exit frame did not halt");
`endif

endmodule
